### src/pbs_pkg.sv
// Package with the shared constants, register codes and saturation helpers.
`timescale 1ns / 1ps

package pbs_pkg;

    // Fixed point format and field widths.
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 20;
    localparam int VEL_W     = 18;
    localparam int DT_W      = 16;
    localparam int CFG_W     = 17;

    // Internal widths: wall-stage position, mirrored velocity, quotient bits.
    localparam int XW = 23;
    localparam int VW = 19;
    localparam int QB = 19;

    localparam logic signed [XW-1:0] ONE = XW'(1) <<< FRAC_BITS;

    // Register reset values.
    localparam logic [DT_W-1:0]  TIME_STEP_RST = 16'd655;
    localparam logic [CFG_W-1:0] CENTER_RST    = 17'd32768;
    localparam logic [CFG_W-1:0] RADIUS_RST    = 17'd13107;

    // Register indexes.
    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_CENTER_X  = 2'd1;
    localparam logic [1:0] REG_CENTER_Y  = 2'd2;
    localparam logic [1:0] REG_RADIUS    = 2'd3;

    // Data carried alongside the divider.
    typedef struct packed {
        logic signed [XW-1:0] pos_x;
        logic signed [XW-1:0] pos_y;
        logic signed [VW-1:0] vel_x;
        logic signed [VW-1:0] vel_y;
        logic                 hit;
        logic                 degen;
        logic                 neg_x;
        logic                 neg_y;
        logic [31:0]          dvs;
    } carry_t;

    // Saturate a wide position to the output field range.
    function automatic logic [POS_W-1:0] sat_pos(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = XW'((1 <<< (POS_W - 1)) - 1);
        lo = -hi - XW'(1);
        if (v > hi)
            return hi[POS_W-1:0];
        else if (v < lo)
            return lo[POS_W-1:0];
        else
            return v[POS_W-1:0];
    endfunction

    // Saturate a wide velocity to the output field range.
    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VW+1:0] v);
        logic signed [VW+1:0] hi;
        logic signed [VW+1:0] lo;
        hi = (VW+2)'((1 <<< (VEL_W - 1)) - 1);
        lo = -hi - (VW+2)'(1);
        if (v > hi)
            return hi[VEL_W-1:0];
        else if (v < lo)
            return lo[VEL_W-1:0];
        else
            return v[VEL_W-1:0];
    endfunction

endpackage

### src/pbs_particle_if.sv
// Channel interface that carries one particle state per transaction.
`timescale 1ns / 1ps

interface pbs_particle_if;
    logic                              valid;
    logic                              ready;
    logic signed [pbs_pkg::POS_W-1:0]  pos_x;
    logic signed [pbs_pkg::POS_W-1:0]  pos_y;
    logic signed [pbs_pkg::VEL_W-1:0]  vel_x;
    logic signed [pbs_pkg::VEL_W-1:0]  vel_y;

    modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                    output ready);
endinterface

### src/pbs_result_if.sv
// Channel interface that carries one updated particle state per transaction.
`timescale 1ns / 1ps

interface pbs_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [pbs_pkg::POS_W-1:0]  new_pos_x;
    logic signed [pbs_pkg::POS_W-1:0]  new_pos_y;
    logic signed [pbs_pkg::VEL_W-1:0]  new_vel_x;
    logic signed [pbs_pkg::VEL_W-1:0]  new_vel_y;
    logic                              hit_obstacle;
    logic                              degenerate_hit;

    modport source (output valid, output new_pos_x, output new_pos_y, output new_vel_x,
                    output new_vel_y, output hit_obstacle, output degenerate_hit,
                    input ready);
    modport sink   (input valid, input new_pos_x, input new_pos_y, input new_vel_x,
                    input new_vel_y, input hit_obstacle, input degenerate_hit,
                    output ready);
endinterface

### src/particle_bounce_step.sv
// Top level: pipelined particle step with wall mirroring and circle reflection.
// Throughput: one particle per cycle while result.ready is not held low; the 19-stage restoring divider sets the depth.
// Each stage holds its data under back-pressure and refills as soon as it empties.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps

module particle_bounce_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [pbs_pkg::CFG_W-1:0]   cfg_data,
    pbs_particle_if.sink                particle,
    pbs_result_if.source                result
);

    localparam int XW = pbs_pkg::XW;
    localparam int VW = pbs_pkg::VW;
    localparam int QB = pbs_pkg::QB;
    localparam int FB = pbs_pkg::FRAC_BITS;
    localparam int DIV0 = 6;
    localparam int NS = DIV0 + QB + 2;

    // Configuration registers.
    logic [pbs_pkg::DT_W-1:0]  time_step_reg;
    logic [pbs_pkg::CFG_W-1:0] center_x_reg;
    logic [pbs_pkg::CFG_W-1:0] center_y_reg;
    logic [pbs_pkg::CFG_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= pbs_pkg::TIME_STEP_RST;
            center_x_reg  <= pbs_pkg::CENTER_RST;
            center_y_reg  <= pbs_pkg::CENTER_RST;
            radius_reg    <= pbs_pkg::RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbs_pkg::REG_TIME_STEP: time_step_reg <= cfg_data[pbs_pkg::DT_W-1:0];
                pbs_pkg::REG_CENTER_X:  center_x_reg  <= cfg_data;
                pbs_pkg::REG_CENTER_Y:  center_y_reg  <= cfg_data;
                pbs_pkg::REG_RADIUS:    radius_reg    <= cfg_data;
            endcase
        end
    end

    logic signed [16:0] dt_s;
    assign dt_s = $signed({1'b0, time_step_reg});

    // Stage valid bits and per-stage load enables; a stage loads when empty or moving on.
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = result.ready;
        for (int k = NS - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= particle.valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign particle.ready = en[0];

    // Stage 0: velocity times step.
    logic signed [pbs_pkg::POS_W-1:0] s0_x_reg, s0_y_reg;
    logic signed [pbs_pkg::VEL_W-1:0] s0_vx_reg, s0_vy_reg;
    logic signed [VW-1:0]             s0_mx_reg, s0_my_reg;
    logic signed [34:0]               s0_px, s0_py;

    assign s0_px = particle.vel_x * dt_s;
    assign s0_py = particle.vel_y * dt_s;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_x_reg  <= particle.pos_x;
            s0_y_reg  <= particle.pos_y;
            s0_vx_reg <= particle.vel_x;
            s0_vy_reg <= particle.vel_y;
            s0_mx_reg <= s0_px[FB+VW-1:FB];
            s0_my_reg <= s0_py[FB+VW-1:FB];
        end
    end

    // Stage 1: advance and mirror at the walls in the order left, bottom, right, top.
    logic signed [XW-1:0] s1_x_next, s1_y_next, s1_x_reg, s1_y_reg;
    logic signed [VW-1:0] s1_vx_next, s1_vy_next, s1_vx_reg, s1_vy_reg;

    always_comb
    begin
        s1_x_next  = XW'(s0_x_reg) + XW'(s0_mx_reg);
        s1_y_next  = XW'(s0_y_reg) + XW'(s0_my_reg);
        s1_vx_next = VW'(s0_vx_reg);
        s1_vy_next = VW'(s0_vy_reg);
        if (s1_x_next < 0)
        begin
            s1_x_next  = -s1_x_next;
            s1_vx_next = -s1_vx_next;
        end
        if (s1_y_next < 0)
        begin
            s1_y_next  = -s1_y_next;
            s1_vy_next = -s1_vy_next;
        end
        if (s1_x_next > pbs_pkg::ONE)
        begin
            s1_x_next  = (pbs_pkg::ONE <<< 1) - s1_x_next;
            s1_vx_next = -s1_vx_next;
        end
        if (s1_y_next > pbs_pkg::ONE)
        begin
            s1_y_next  = (pbs_pkg::ONE <<< 1) - s1_y_next;
            s1_vy_next = -s1_vy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_x_reg  <= s1_x_next;
            s1_y_reg  <= s1_y_next;
            s1_vx_reg <= s1_vx_next;
            s1_vy_reg <= s1_vy_next;
        end
    end

    // Stage 2: offset from the centre and the rollback step.
    logic signed [XW:0]   s2_dx_reg, s2_dy_reg;
    logic signed [XW-1:0] s2_x_reg, s2_y_reg;
    logic signed [VW-1:0] s2_vx_reg, s2_vy_reg, s2_mx_reg, s2_my_reg;
    logic signed [35:0]   s2_px, s2_py;

    assign s2_px = s1_vx_reg * dt_s;
    assign s2_py = s1_vy_reg * dt_s;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_dx_reg <= (XW+1)'(s1_x_reg) - $signed({7'b0, center_x_reg});
            s2_dy_reg <= (XW+1)'(s1_y_reg) - $signed({7'b0, center_y_reg});
            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_mx_reg <= s2_px[FB+VW-1:FB];
            s2_my_reg <= s2_py[FB+VW-1:FB];
        end
    end

    // Stage 3: squares, velocity products, radius squared and rolled-back position.
    logic [46:0]          s3_dx2_reg, s3_dy2_reg;
    logic [33:0]          s3_r2_reg;
    logic signed [36:0]   s3_pvx_reg, s3_pvy_reg;
    logic signed [17:0]   s3_dxs_reg, s3_dys_reg;
    logic signed [XW-1:0] s3_x_reg, s3_y_reg, s3_xr_reg, s3_yr_reg;
    logic signed [VW-1:0] s3_vx_reg, s3_vy_reg;
    logic signed [47:0]   s3_sqx, s3_sqy;

    assign s3_sqx = s2_dx_reg * s2_dx_reg;
    assign s3_sqy = s2_dy_reg * s2_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_dx2_reg <= s3_sqx[46:0];
            s3_dy2_reg <= s3_sqy[46:0];
            s3_r2_reg  <= radius_reg * radius_reg;
            s3_pvx_reg <= s2_vx_reg * $signed(s2_dx_reg[17:0]);
            s3_pvy_reg <= s2_vy_reg * $signed(s2_dy_reg[17:0]);
            s3_dxs_reg <= s2_dx_reg[17:0];
            s3_dys_reg <= s2_dy_reg[17:0];
            s3_x_reg   <= s2_x_reg;
            s3_y_reg   <= s2_y_reg;
            s3_xr_reg  <= s2_x_reg - XW'(s2_mx_reg);
            s3_yr_reg  <= s2_y_reg - XW'(s2_my_reg);
            s3_vx_reg  <= s2_vx_reg;
            s3_vy_reg  <= s2_vy_reg;
        end
    end

    // Stage 4: squared distance and dot product.
    logic [47:0]          s4_d2_reg;
    logic [33:0]          s4_r2_reg;
    logic signed [37:0]   s4_vd_reg;
    logic signed [17:0]   s4_dxs_reg, s4_dys_reg;
    logic signed [XW-1:0] s4_x_reg, s4_y_reg, s4_xr_reg, s4_yr_reg;
    logic signed [VW-1:0] s4_vx_reg, s4_vy_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_d2_reg  <= 48'(s3_dx2_reg) + 48'(s3_dy2_reg);
            s4_r2_reg  <= s3_r2_reg;
            s4_vd_reg  <= 38'(s3_pvx_reg) + 38'(s3_pvy_reg);
            s4_dxs_reg <= s3_dxs_reg;
            s4_dys_reg <= s3_dys_reg;
            s4_x_reg   <= s3_x_reg;
            s4_y_reg   <= s3_y_reg;
            s4_xr_reg  <= s3_xr_reg;
            s4_yr_reg  <= s3_yr_reg;
            s4_vx_reg  <= s3_vx_reg;
            s4_vy_reg  <= s3_vy_reg;
        end
    end

    // Stage 5: inside test, position choice and reflection numerators.
    logic                 s5_hit;
    logic signed [36:0]   s5_vd2;
    logic signed [54:0]   s5_nx_reg, s5_ny_reg;
    pbs_pkg::carry_t      s5_c_reg;

    assign s5_hit = s4_d2_reg < {14'b0, s4_r2_reg};
    assign s5_vd2 = {s4_vd_reg[35:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_nx_reg      <= s5_vd2 * s4_dxs_reg;
            s5_ny_reg      <= s5_vd2 * s4_dys_reg;
            s5_c_reg.pos_x <= s5_hit ? s4_xr_reg : s4_x_reg;
            s5_c_reg.pos_y <= s5_hit ? s4_yr_reg : s4_y_reg;
            s5_c_reg.vel_x <= s4_vx_reg;
            s5_c_reg.vel_y <= s4_vy_reg;
            s5_c_reg.hit   <= s5_hit;
            s5_c_reg.degen <= s5_hit && (s4_d2_reg == '0);
            s5_c_reg.neg_x <= 1'b0;
            s5_c_reg.neg_y <= 1'b0;
            s5_c_reg.dvs   <= s4_d2_reg[31:0];
        end
    end

    // Stage 6 and divider: magnitudes, then one quotient bit per stage.
    logic [51:0]     rx_reg [QB+1];
    logic [51:0]     ry_reg [QB+1];
    logic [QB-1:0]   qx_reg [QB+1];
    logic [QB-1:0]   qy_reg [QB+1];
    pbs_pkg::carry_t dc_reg [QB+1];
    logic signed [54:0] s6_ax, s6_ay;
    pbs_pkg::carry_t    s6_c;

    assign s6_ax = s5_nx_reg[54] ? -s5_nx_reg : s5_nx_reg;
    assign s6_ay = s5_ny_reg[54] ? -s5_ny_reg : s5_ny_reg;

    // The numerator signs travel with the carried data.
    always_comb
    begin
        s6_c       = s5_c_reg;
        s6_c.neg_x = s5_nx_reg[54];
        s6_c.neg_y = s5_ny_reg[54];
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV0])
        begin
            rx_reg[0] <= s6_ax[51:0];
            ry_reg[0] <= s6_ay[51:0];
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            dc_reg[0] <= s6_c;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        localparam int BIT = QB - j;
        logic [51:0] sub;
        logic        take_x, take_y;

        assign sub    = {20'b0, dc_reg[j-1].dvs} << BIT;
        assign take_x = rx_reg[j-1] >= sub;
        assign take_y = ry_reg[j-1] >= sub;

        always_ff @(posedge clk)
        begin
            if (en[DIV0+j])
            begin
                rx_reg[j] <= take_x ? rx_reg[j-1] - sub : rx_reg[j-1];
                ry_reg[j] <= take_y ? ry_reg[j-1] - sub : ry_reg[j-1];
                qx_reg[j] <= qx_reg[j-1] | (QB'(take_x) << BIT);
                qy_reg[j] <= qy_reg[j-1] | (QB'(take_y) << BIT);
                dc_reg[j] <= dc_reg[j-1];
            end
        end
    end

    // Output stage: apply the reflection and saturate.
    logic signed [VW+1:0] fq_x, fq_y, fv_x, fv_y;
    pbs_pkg::carry_t      fc;
    logic                 refl;

    assign fc   = dc_reg[QB];
    assign refl = fc.hit && !fc.degen;
    assign fq_x = fc.neg_x ? -$signed({2'b0, qx_reg[QB]}) : $signed({2'b0, qx_reg[QB]});
    assign fq_y = fc.neg_y ? -$signed({2'b0, qy_reg[QB]}) : $signed({2'b0, qy_reg[QB]});
    assign fv_x = (VW+2)'(fc.vel_x) - (refl ? fq_x : '0);
    assign fv_y = (VW+2)'(fc.vel_y) - (refl ? fq_y : '0);

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            result.new_pos_x      <= pbs_pkg::sat_pos(fc.pos_x);
            result.new_pos_y      <= pbs_pkg::sat_pos(fc.pos_y);
            result.new_vel_x      <= pbs_pkg::sat_vel(fv_x);
            result.new_vel_y      <= pbs_pkg::sat_vel(fv_y);
            result.hit_obstacle   <= fc.hit;
            result.degenerate_hit <= fc.degen;
        end
    end

    assign result.valid = v_reg[NS-1];

`ifndef ASSERT_OFF
    // A degenerate hit is always also a hit.
    a_degen_hit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.degenerate_hit || result.hit_obstacle))
        else $error("degenerate_hit without hit_obstacle");

    // An empty output stage never blocks new particles.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS-1] |-> particle.ready)
        else $error("input stalled with empty output stage");

    // After the last divider step the remainder lies below the divisor on a reflection.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-2] && refl) |-> ((rx_reg[QB] < 52'(fc.dvs)) && (ry_reg[QB] < 52'(fc.dvs))))
        else $error("divider remainder out of range");

    // A held last divider stage keeps its valid bit.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-2] && !en[NS-2]) |=> v_reg[NS-2])
        else $error("stalled stage lost its transaction");
`endif

endmodule
